// ===== rtl/assert_macros.svh =====
// Assertion macros for the checker file rmv_checker.sv.
// Depends on nothing; take it in with `include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property with a reset that switches the check off.
`define RMV_ASSERT_RST(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked property that is checked during reset too.
`define RMV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/rmv_pkg.sv =====
// Shared types and constants of the running mean / variance accumulator.
// Used by rmv_iter_unit, the top level and the checker; depends on nothing.
package rmv_pkg;

    localparam int SAMPLE_BITS = 32;
    localparam int COUNT_BITS  = 16;
    localparam int MEAN_W      = SAMPLE_BITS + 16;
    localparam int VAR_W       = 64;
    localparam int RMS_W       = 32;
    localparam int PROD_W      = 96;
    localparam int DQ_W        = 80;
    localparam int ROOT_W      = 32;
    localparam int CNT_W       = 7;
    localparam int CFG_W       = 16;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [15:0]           MISM_MAX  = '1;

    localparam logic REG_AVERAGE_WINDOW = 1'b0;
    localparam logic REG_SEVERITY_LIMIT = 1'b1;

    typedef enum logic [1:0] {
        UOP_MUL,
        UOP_DIV,
        UOP_SQRT
    } uop_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [1:0]                    severity;
        logic                          stamps_match;
        logic                          new_cycle;
        logic                          force_restart;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] mean;
        logic [VAR_W-1:0]              variance;
        logic [RMS_W-1:0]              rms;
        logic [COUNT_BITS-1:0]         good_count;
        logic                          history_enable;
        logic [31:0]                   total_count;
        logic [31:0]                   window_count;
        logic [15:0]                   mismatch_count;
        logic                          error;
    } out_t;

    typedef struct packed {
        logic              start;
        uop_t              op;
        logic [CNT_W-1:0]  count;
        logic [PROD_W-1:0] opa;
        logic [63:0]       opb;
    } unit_req_t;

    typedef struct packed {
        logic              done;
        logic [PROD_W-1:0] result;
    } unit_sts_t;

endpackage

// ===== rtl/rmv_iter_unit.sv =====
// Iterative arithmetic unit: shift-add multiply, restoring divide, integer sqrt.
// One bit (or one root digit) per cycle; depends on rmv_pkg.
module rmv_iter_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  rmv_pkg::unit_req_t  req,
    output rmv_pkg::unit_sts_t  sts
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    rmv_pkg::uop_t               op_reg, op_next;
    logic [rmv_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [rmv_pkg::PROD_W-1:0]  acc_reg, acc_next;
    logic [rmv_pkg::PROD_W-1:0]  mcand_reg, mcand_next;
    logic [63:0]                 aux_reg, aux_next;
    logic [rmv_pkg::DQ_W-1:0]    dq_reg, dq_next;
    logic [32:0]                 rem_reg, rem_next;

    logic [16:0] dtrial, ddiff;
    logic        dge;
    logic [33:0] sw, st, sdiff;
    logic        sge;

    always_comb begin
        dtrial = {rem_reg[15:0], dq_reg[rmv_pkg::DQ_W-1]};
        ddiff  = dtrial - {1'b0, aux_reg[15:0]};
        dge    = dtrial >= {1'b0, aux_reg[15:0]};
        sw     = {rem_reg[31:0], dq_reg[rmv_pkg::DQ_W-1 -: 2]};
        st     = {aux_reg[31:0], 2'b01};
        sge    = sw >= st;
        sdiff  = sw - st;
    end

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        op_next    = op_reg;
        cnt_next   = cnt_reg;
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        aux_next   = aux_reg;
        dq_next    = dq_reg;
        rem_next   = rem_reg;
        if (req.start) begin
            busy_next  = 1'b1;
            op_next    = req.op;
            cnt_next   = req.count;
            acc_next   = '0;
            mcand_next = req.opa;
            rem_next   = '0;
            if (req.op == rmv_pkg::UOP_SQRT) begin
                aux_next = '0;
                dq_next  = {req.opa[63:0], 16'b0};
            end else begin
                aux_next = req.opb;
                dq_next  = req.opa[rmv_pkg::DQ_W-1:0];
            end
        end else if (busy_reg) begin
            unique case (op_reg)
                rmv_pkg::UOP_MUL: begin
                    if (aux_reg[0]) begin
                        acc_next = acc_reg + mcand_reg;
                    end
                    mcand_next = {mcand_reg[rmv_pkg::PROD_W-2:0], 1'b0};
                    aux_next   = {1'b0, aux_reg[63:1]};
                end
                rmv_pkg::UOP_DIV: begin
                    rem_next = {17'b0, (dge ? ddiff[15:0] : dtrial[15:0])};
                    dq_next  = {dq_reg[rmv_pkg::DQ_W-2:0], dge};
                end
                rmv_pkg::UOP_SQRT: begin
                    rem_next = sge ? sdiff[32:0] : sw[32:0];
                    aux_next = {aux_reg[62:0], sge};
                    dq_next  = {dq_reg[rmv_pkg::DQ_W-3:0], 2'b00};
                end
                default: begin
                    busy_next = 1'b0;
                end
            endcase
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == rmv_pkg::CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= rmv_pkg::UOP_MUL;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        aux_reg   <= aux_next;
        dq_reg    <= dq_next;
        rem_reg   <= rem_next;
    end

    always_comb begin
        sts.done = done_reg;
        unique case (op_reg)
            rmv_pkg::UOP_MUL:  sts.result = acc_reg;
            rmv_pkg::UOP_DIV:  sts.result = {16'b0, dq_reg};
            rmv_pkg::UOP_SQRT: sts.result = {64'b0, aux_reg[rmv_pkg::ROOT_W-1:0]};
            default:           sts.result = '0;
        endcase
    end

endmodule

// ===== rtl/running_mean_variance_accumulator_top.sv =====
// A timestamp mismatch or a good count of at most one finishes from idle; a full
// Welford update runs the unit steps, and when a window ends rms adds a 64-step
// divide and a 32-step root. No new beat is taken until the last result reaches
// the output register: every step runs through the single bit-serial rmv_iter_unit.
// Reset: synchronous active-low aresetn zeroes control, config and accumulator registers.
// Top level: sequencer, state registers, output register; uses rmv_pkg and rmv_iter_unit.
module running_mean_variance_accumulator_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  rmv_pkg::in_t               s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output rmv_pkg::out_t              m_data,
    input  logic                       cfg_wr_en,
    input  logic                       cfg_index,
    input  logic [rmv_pkg::CFG_W-1:0]  cfg_wdata
);

    // Sequencer: each unit operation has an issue state and a wait state.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIFF,
        ST_M_GO,  ST_M_WT,
        ST_V1_GO, ST_V1_WT,
        ST_D1_GO, ST_D1_WT,
        ST_V2_GO, ST_V2_WT,
        ST_D2_GO, ST_D2_WT,
        ST_R_GO,  ST_R_WT,
        ST_S_GO,  ST_S_WT
    } state_t;

    localparam int CB = rmv_pkg::COUNT_BITS;
    localparam int MW = rmv_pkg::MEAN_W;

    state_t state_reg;
    logic   finish_reg;

    // Configuration.
    logic [CB-1:0] awin_reg;
    logic [1:0]    slim_reg;

    // Accumulator state.
    logic [MW-1:0]             mean_reg;
    logic [rmv_pkg::VAR_W-1:0] var_reg;
    logic [rmv_pkg::RMS_W-1:0] rms_reg;
    logic [CB-1:0]             good_reg;
    logic [CB-1:0]             wpos_reg;
    logic [31:0]               total_reg;
    logic [31:0]               windows_reg;
    logic [15:0]               mism_reg;
    logic                      restart_reg;

    // Per-beat working registers.
    logic [MW-1:0]             xs_reg;
    logic [MW-1:0]             mag_reg;
    logic                      neg_reg;
    logic [rmv_pkg::VAR_W-1:0] t1_reg;
    logic                      hist_reg;
    logic                      err_reg;

    logic          m_valid_reg;
    rmv_pkg::out_t out_reg;

    rmv_pkg::unit_req_t req;
    rmv_pkg::unit_sts_t sts;

    // Counter updates taken at the accept edge.
    logic [MW-1:0]  xs_w;
    logic           clr;
    logic [MW-1:0]  mean_next;
    logic [CB-1:0]  good_next, wpos_next;
    logic [15:0]    mism_next, mism_bump;
    logic [31:0]    total_next, windows_next;
    logic           restart_next, hist_next;

    logic [MW-1:0]  diff_w;
    logic           lt_w;
    logic [64:0]    vsum;

    assign s_ready = (state_reg == ST_IDLE) && !finish_reg;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        xs_w         = {s_data.sample, 16'b0};
        clr          = restart_reg | s_data.force_restart;
        mean_next    = clr ? '0 : mean_reg;
        good_next    = clr ? '0 : good_reg;
        wpos_next    = clr ? '0 : wpos_reg;
        mism_next    = clr ? '0 : mism_reg;
        restart_next = clr ? 1'b0 : restart_reg;
        total_next   = s_data.new_cycle ? '0 : total_reg;
        windows_next = s_data.new_cycle ? '0 : windows_reg;
        hist_next    = 1'b0;
        if (awin_reg == '0) begin
            // No averaging: restart on every pulse.
            restart_next = 1'b1;
        end else begin
            if ((s_data.severity <= slim_reg) && (good_next != rmv_pkg::COUNT_MAX)) begin
                good_next = good_next + 1'b1;
            end
            if (wpos_next != rmv_pkg::COUNT_MAX) begin
                wpos_next = wpos_next + 1'b1;
            end
            if ((wpos_next >= awin_reg) || (wpos_next == rmv_pkg::COUNT_MAX)) begin
                hist_next    = 1'b1;
                wpos_next    = '0;
                restart_next = 1'b1;
                windows_next = windows_next + 1'b1;
            end else begin
                restart_next = 1'b0;
            end
        end
        total_next = total_next + 1'b1;
        mism_bump  = (mism_reg != rmv_pkg::MISM_MAX) ? mism_reg + 1'b1 : mism_reg;
    end

    always_comb begin
        lt_w   = $signed(xs_reg) < $signed(mean_reg);
        diff_w = lt_w ? (mean_reg - xs_reg) : (xs_reg - mean_reg);
        vsum   = {1'b0, t1_reg} + {1'b0, sts.result[rmv_pkg::VAR_W-1:0]};
    end

    // Operand routing for the shared unit.
    always_comb begin
        req       = '0;
        req.op    = rmv_pkg::UOP_DIV;
        unique case (state_reg)
            ST_M_GO: begin
                // mag / n, quotient truncated
                req.start = 1'b1;
                req.count = rmv_pkg::CNT_W'(MW);
                req.opa   = {16'b0, mag_reg, 32'b0};
                req.opb   = {48'b0, good_reg};
            end
            ST_V1_GO: begin
                req.start = 1'b1;
                req.op    = rmv_pkg::UOP_MUL;
                req.count = rmv_pkg::CNT_W'(CB);
                req.opa   = {32'b0, var_reg};
                req.opb   = {48'b0, good_reg - CB'(2)};
            end
            ST_D1_GO: begin
                req.start = 1'b1;
                req.count = rmv_pkg::CNT_W'(rmv_pkg::DQ_W);
                req.opa   = {16'b0, sts.result[rmv_pkg::DQ_W-1:0]};
                req.opb   = {48'b0, good_reg - CB'(1)};
            end
            ST_V2_GO: begin
                req.start = 1'b1;
                req.op    = rmv_pkg::UOP_MUL;
                req.count = rmv_pkg::CNT_W'(MW);
                req.opa   = {48'b0, mag_reg};
                req.opb   = {16'b0, mag_reg};
            end
            ST_D2_GO: begin
                // drop the low 32 bits of d^2 to land in Q64.0
                req.start = 1'b1;
                req.count = rmv_pkg::CNT_W'(64);
                req.opa   = {16'b0, sts.result[95:32], 16'b0};
                req.opb   = {48'b0, good_reg};
            end
            ST_R_GO: begin
                req.start = 1'b1;
                req.count = rmv_pkg::CNT_W'(64);
                req.opa   = {16'b0, var_reg, 16'b0};
                req.opb   = {48'b0, good_reg};
            end
            ST_S_GO: begin
                req.start = 1'b1;
                req.op    = rmv_pkg::UOP_SQRT;
                req.count = rmv_pkg::CNT_W'(rmv_pkg::ROOT_W);
                req.opa   = {32'b0, sts.result[63:0]};
            end
            default: begin
                req.start = 1'b0;
            end
        endcase
    end

    rmv_iter_unit u_unit (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .sts     (sts)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            finish_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
            awin_reg    <= '0;
            slim_reg    <= '0;
            mean_reg    <= '0;
            var_reg     <= '0;
            rms_reg     <= '0;
            good_reg    <= '0;
            wpos_reg    <= '0;
            total_reg   <= '0;
            windows_reg <= '0;
            mism_reg    <= '0;
            restart_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    rmv_pkg::REG_AVERAGE_WINDOW: awin_reg <= cfg_wdata[CB-1:0];
                    rmv_pkg::REG_SEVERITY_LIMIT: slim_reg <= cfg_wdata[1:0];
                endcase
            end

            // Hold the finished result until the output register is free;
            // otherwise drop the output beat once taken.
            if (finish_reg && (!m_valid_reg || m_ready)) begin
                m_valid_reg            <= 1'b1;
                finish_reg             <= 1'b0;
                out_reg.mean           <= mean_reg[MW-1:16];
                out_reg.variance       <= var_reg;
                out_reg.rms            <= rms_reg;
                out_reg.good_count     <= good_reg;
                out_reg.history_enable <= hist_reg;
                out_reg.total_count    <= total_reg;
                out_reg.window_count   <= windows_reg;
                out_reg.mismatch_count <= mism_reg;
                out_reg.error          <= err_reg;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        if (!s_data.stamps_match) begin
                            // Ignore the sample, bump the mismatch count only.
                            mism_reg   <= mism_bump;
                            err_reg    <= 1'b1;
                            hist_reg   <= 1'b0;
                            finish_reg <= 1'b1;
                        end else begin
                            err_reg     <= 1'b0;
                            hist_reg    <= hist_next;
                            xs_reg      <= xs_w;
                            good_reg    <= good_next;
                            wpos_reg    <= wpos_next;
                            mism_reg    <= mism_next;
                            total_reg   <= total_next;
                            windows_reg <= windows_next;
                            restart_reg <= restart_next;
                            if (good_next <= CB'(1)) begin
                                // A good count of at most one seeds the mean with the sample.
                                mean_reg   <= xs_w;
                                var_reg    <= '0;
                                rms_reg    <= '0;
                                finish_reg <= 1'b1;
                            end else begin
                                mean_reg  <= mean_next;
                                state_reg <= ST_DIFF;
                            end
                        end
                    end
                end
                ST_DIFF: begin
                    neg_reg   <= lt_w;
                    mag_reg   <= diff_w;
                    state_reg <= ST_M_GO;
                end
                ST_M_GO:  state_reg <= ST_M_WT;
                ST_M_WT: begin
                    if (sts.done) begin
                        mean_reg  <= neg_reg ? (mean_reg - sts.result[MW-1:0])
                                             : (mean_reg + sts.result[MW-1:0]);
                        state_reg <= ST_V1_GO;
                    end
                end
                ST_V1_GO: state_reg <= ST_V1_WT;
                ST_V1_WT: begin
                    if (sts.done) begin
                        state_reg <= ST_D1_GO;
                    end
                end
                ST_D1_GO: state_reg <= ST_D1_WT;
                ST_D1_WT: begin
                    if (sts.done) begin
                        t1_reg    <= sts.result[rmv_pkg::VAR_W-1:0];
                        state_reg <= ST_V2_GO;
                    end
                end
                ST_V2_GO: state_reg <= ST_V2_WT;
                ST_V2_WT: begin
                    if (sts.done) begin
                        state_reg <= ST_D2_GO;
                    end
                end
                ST_D2_GO: state_reg <= ST_D2_WT;
                ST_D2_WT: begin
                    if (sts.done) begin
                        // Saturate the variance sum at all ones.
                        var_reg <= vsum[64] ? '1 : vsum[rmv_pkg::VAR_W-1:0];
                        if (restart_reg) begin
                            state_reg <= ST_R_GO;
                        end else begin
                            finish_reg <= 1'b1;
                            state_reg  <= ST_IDLE;
                        end
                    end
                end
                ST_R_GO:  state_reg <= ST_R_WT;
                ST_R_WT: begin
                    if (sts.done) begin
                        state_reg <= ST_S_GO;
                    end
                end
                ST_S_GO:  state_reg <= ST_S_WT;
                ST_S_WT: begin
                    if (sts.done) begin
                        rms_reg    <= sts.result[rmv_pkg::RMS_W-1:0];
                        finish_reg <= 1'b1;
                        state_reg  <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/rmv_checker.sv =====
// Port-level checker for the accumulator top level, bound in below.
// Depends on rmv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rmv_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_valid,
    input logic          s_ready,
    input logic          m_valid,
    input logic          m_ready,
    input rmv_pkg::out_t m_data
);

    `RMV_ASSERT_RST(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_data), "output beat changed while stalled")
    `RMV_ASSERT_RST(a_busy_after_accept, aclk, aresetn, s_valid && s_ready |=> !s_ready, "ready stayed high after an accepted beat")
    `RMV_ASSERT_ALWAYS(a_reset_state, aclk, !aresetn |=> !m_valid && s_ready, "reset did not clear output or return to idle")

endmodule

bind running_mean_variance_accumulator_top rmv_checker u_rmv_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
